FILE: hw/rtl/svpc_pkg.sv
package svpc_pkg;

    localparam int VALUE_WIDTH = 24;
    localparam int FRAC_BITS   = 16;
    localparam int GAIN_W      = 24;
    localparam int LIMIT_W     = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd6554;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd3277;

    // datapath widths
    localparam int ERR_W    = VALUE_WIDTH + 1;
    localparam int PROD_W   = ERR_W + GAIN_W + 1;
    localparam int CTL_W    = PROD_W - FRAC_BITS;
    localparam int MAG_W    = CTL_W - 1;
    localparam int NORM_W   = 30;                  // magnitudes kept below 2^30
    localparam int MAGX_W   = (MAG_W > NORM_W) ? MAG_W : NORM_W;
    localparam int SHIFT_W  = $clog2(MAGX_W - NORM_W + 2);
    localparam int SQ_W     = 2 * NORM_W + 2;
    localparam int ROOT_W   = NORM_W + 1;
    localparam int REM_W    = ROOT_W + 2;
    localparam int LIMSQ_W  = 2 * LIMIT_W;
    localparam int MP_W     = NORM_W + LIMIT_W;
    localparam int DIVD_W   = MP_W + 1;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = LIMIT_W;
    localparam int OUT_W    = ((NORM_W > VALUE_WIDTH) ? NORM_W : VALUE_WIDTH) + 1;
    // input, error product, normalize, squares, sum, sqrt steps, scale,
    // dividend, divide steps, output
    localparam int LAT      = 8 + SQ_STEPS + DIV_STEPS;

    typedef logic [VALUE_WIDTH-1:0] t_val;
    typedef logic [2:0][VALUE_WIDTH-1:0] t_vec;

    typedef struct packed {
        t_val goal_pos_x;
        t_val goal_pos_y;
        t_val goal_pos_z;
        t_val goal_rot_x;
        t_val goal_rot_y;
        t_val goal_rot_z;
        t_val meas_pos_x;
        t_val meas_pos_y;
        t_val meas_pos_z;
        t_val meas_rot_x;
        t_val meas_rot_y;
        t_val meas_rot_z;
    } t_in;

    typedef struct packed {
        t_val lin_vel_x;
        t_val lin_vel_y;
        t_val lin_vel_z;
        t_val ang_vel_x;
        t_val ang_vel_y;
        t_val ang_vel_z;
    } t_out;

endpackage

FILE: hw/rtl/svpc_lane.sv
module svpc_lane (
    input  logic                    i_clk,
    input  svpc_pkg::t_vec          i_goal,
    input  svpc_pkg::t_vec          i_meas,
    input  logic [svpc_pkg::GAIN_W-1:0]  i_gain,
    input  logic [svpc_pkg::LIMIT_W-1:0] i_limit,
    input  logic [svpc_pkg::LIMSQ_W-1:0] i_lim_sq,
    output svpc_pkg::t_vec          o_vel
);
    import svpc_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [OUT_W-1:0] MAX_POS = OUT_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
    localparam logic [OUT_W-1:0] MAX_NEG = OUT_W'(64'd1 << (VALUE_WIDTH - 1));

    // P0: error
    logic signed [ERR_W-1:0] r_err [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_err[i] <= ERR_W'($signed(i_goal[i])) - ERR_W'($signed(i_meas[i]));
        end
    end

    // P1: gain, round, magnitude
    logic signed [PROD_W-1:0] prod [3];
    logic signed [PROD_W-1:0] rnd [3];
    logic signed [CTL_W-1:0]  ctl [3];
    logic signed [CTL_W-1:0]  ctl_abs [3];
    logic [MAG_W-1:0] r_mag1 [3];
    logic [2:0]       r_neg1;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i]    = PROD_W'(r_err[i]) * PROD_W'($signed({1'b0, i_gain}));
            rnd[i]     = prod[i] + HALF;
            ctl[i]     = rnd[i][PROD_W-1:FRAC_BITS];
            ctl_abs[i] = ctl[i][CTL_W-1] ? -ctl[i] : ctl[i];
        end
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mag1[i] <= ctl_abs[i][MAG_W-1:0];
            r_neg1[i] <= ctl[i][CTL_W-1];
        end
    end

    // P2: bring large vectors below 2^30
    logic [MAGX_W-1:0]  magx [3];
    logic [MAGX_W-1:0]  orv;
    logic [SHIFT_W-1:0] shamt;
    logic [MAGX_W-1:0]  shifted [3];
    logic [NORM_W-1:0]  r_mag2 [3];
    logic [2:0]         r_neg2;
    logic               r_wide2;
    always_comb begin
        orv = '0;
        for (int i = 0; i < 3; i++) begin
            magx[i] = MAGX_W'(r_mag1[i]);
            orv     = orv | magx[i];
        end
        shamt = '0;
        for (int s = 1; s <= MAGX_W - NORM_W; s++) begin
            if (orv[NORM_W+s-1]) begin
                shamt = SHIFT_W'(s);
            end
        end
        for (int i = 0; i < 3; i++) begin
            shifted[i] = magx[i] >> shamt;
        end
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mag2[i] <= shifted[i][NORM_W-1:0];
        end
        r_neg2  <= r_neg1;
        r_wide2 <= (shamt != '0);
    end

    // P3: squares
    logic [2*NORM_W-1:0] r_sq3 [3];
    logic [NORM_W-1:0]   r_mag3 [3];
    logic [2:0]          r_neg3;
    logic                r_wide3;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq3[i]  <= r_mag2[i] * r_mag2[i];
            r_mag3[i] <= r_mag2[i];
        end
        r_neg3  <= r_neg2;
        r_wide3 <= r_wide2;
    end

    // P4: norm squared and limit test; feeds the square root chain
    logic [SQ_W-1:0]   n2;
    logic [SQ_W-1:0]   r_sq_rad  [0:SQ_STEPS];
    logic [REM_W-1:0]  r_sq_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0] r_sq_root [0:SQ_STEPS];
    logic [NORM_W-1:0] r_sq_mag  [0:SQ_STEPS][3];
    logic [2:0]        r_sq_neg  [0:SQ_STEPS];
    logic              r_sq_pass [0:SQ_STEPS];
    assign n2 = SQ_W'(r_sq3[0]) + SQ_W'(r_sq3[1]) + SQ_W'(r_sq3[2]);
    always_ff @(posedge i_clk) begin
        r_sq_rad[0]  <= n2;
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_mag[0]  <= r_mag3;
        r_sq_neg[0]  <= r_neg3;
        r_sq_pass[0] <= !r_wide3 && (n2 <= SQ_W'(i_lim_sq));
    end

    // one root bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] sub;
        logic             take;
        always_comb begin
            trial = {r_sq_rem[j], r_sq_rad[j][SQ_W-1:SQ_W-2]};
            sub   = (REM_W+2)'({r_sq_root[j], 2'b01});
            take  = trial >= sub;
        end
        always_ff @(posedge i_clk) begin
            r_sq_rad[j+1]  <= r_sq_rad[j] << 2;
            r_sq_rem[j+1]  <= take ? REM_W'(trial - sub) : REM_W'(trial);
            r_sq_root[j+1] <= {r_sq_root[j][ROOT_W-2:0], take};
            r_sq_mag[j+1]  <= r_sq_mag[j];
            r_sq_neg[j+1]  <= r_sq_neg[j];
            r_sq_pass[j+1] <= r_sq_pass[j];
        end
    end

    // scale by the limit
    logic [MP_W-1:0]   r_mp [3];
    logic [ROOT_W-1:0] r_mp_n;
    logic [NORM_W-1:0] r_mp_mag [3];
    logic [2:0]        r_mp_neg;
    logic              r_mp_pass;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_mp[i]     <= r_sq_mag[SQ_STEPS][i] * i_limit;
            r_mp_mag[i] <= r_sq_mag[SQ_STEPS][i];
        end
        r_mp_n    <= r_sq_root[SQ_STEPS];
        r_mp_neg  <= r_sq_neg[SQ_STEPS];
        r_mp_pass <= r_sq_pass[SQ_STEPS];
    end

    // rounded dividend; quotient never exceeds the limit
    logic [DIVD_W-1:0]  dvd [3];
    logic [ROOT_W-1:0]  r_dv_rem  [0:DIV_STEPS][3];
    logic [LIMIT_W-1:0] r_dv_low  [0:DIV_STEPS][3];
    logic [LIMIT_W-1:0] r_dv_q    [0:DIV_STEPS][3];
    logic [ROOT_W-1:0]  r_dv_n    [0:DIV_STEPS];
    logic [NORM_W-1:0]  r_dv_mag  [0:DIV_STEPS][3];
    logic [2:0]         r_dv_neg  [0:DIV_STEPS];
    logic               r_dv_pass [0:DIV_STEPS];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dvd[i] = DIVD_W'(r_mp[i]) + DIVD_W'(r_mp_n >> 1);
        end
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dv_rem[0][i] <= dvd[i][DIVD_W-1:LIMIT_W];
            r_dv_low[0][i] <= dvd[i][LIMIT_W-1:0];
            r_dv_q[0][i]   <= '0;
        end
        r_dv_n[0]    <= r_mp_n;
        r_dv_mag[0]  <= r_mp_mag;
        r_dv_neg[0]  <= r_mp_neg;
        r_dv_pass[0] <= r_mp_pass;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [ROOT_W:0] t [3];
        logic [2:0]      take;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t[i]    = {r_dv_rem[k][i], r_dv_low[k][i][LIMIT_W-1]};
                take[i] = t[i] >= {1'b0, r_dv_n[k]};
            end
        end
        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[k+1][i] <= take[i] ? ROOT_W'(t[i] - {1'b0, r_dv_n[k]})
                                            : ROOT_W'(t[i]);
                r_dv_low[k+1][i] <= r_dv_low[k][i] << 1;
                r_dv_q[k+1][i]   <= {r_dv_q[k][i][LIMIT_W-2:0], take[i]};
            end
            r_dv_n[k+1]    <= r_dv_n[k];
            r_dv_mag[k+1]  <= r_dv_mag[k];
            r_dv_neg[k+1]  <= r_dv_neg[k];
            r_dv_pass[k+1] <= r_dv_pass[k];
        end
    end

    // select, sign, saturate
    logic [OUT_W-1:0] val [3];
    logic [OUT_W-1:0] res [3];
    t_vec             r_vel;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            val[i] = r_dv_pass[DIV_STEPS] ? OUT_W'(r_dv_mag[DIV_STEPS][i])
                                          : OUT_W'(r_dv_q[DIV_STEPS][i]);
            if (r_dv_neg[DIV_STEPS][i]) begin
                res[i] = (val[i] > MAX_NEG) ? -MAX_NEG : -val[i];
            end else begin
                res[i] = (val[i] > MAX_POS) ? MAX_POS : val[i];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_vel[i] <= res[i][VALUE_WIDTH-1:0];
        end
    end
    assign o_vel = r_vel;

endmodule

FILE: hw/rtl/saturated_vector_p_controller.sv
// Proportional pose controller: each item (goal and measured pose) yields one
// result, linear and angular velocity, each vector's norm limited to
// speed_limit. Fully pipelined: an item may be started every cycle (busy
// never rises). The datapath is 62 register stages deep: o_strobe and the
// result rise together, and the depth is set by the 31-step square root
// and the 23-step divide chains. o_strobe lasts one cycle and cannot be
// held off.
module saturated_vector_p_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  svpc_pkg::t_in                      i_in,
    output logic                               o_strobe,
    output svpc_pkg::t_out                     o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [svpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [svpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import svpc_pkg::*;

    logic [GAIN_W-1:0]  r_gain;
    logic [LIMIT_W-1:0] r_limit;
    logic [LIMSQ_W-1:0] r_lim_sq;
    logic [LAT-1:0]     r_vld;
    logic               cfg_wr;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_limit <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_GAIN:        r_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_SPEED_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_sq <= r_limit * r_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start && !o_busy};
        end
    end
    assign o_strobe = r_vld[LAT-1];

    t_vec goal_pos, meas_pos, goal_rot, meas_rot, lin_vel, ang_vel;
    assign goal_pos = {i_in.goal_pos_z, i_in.goal_pos_y, i_in.goal_pos_x};
    assign meas_pos = {i_in.meas_pos_z, i_in.meas_pos_y, i_in.meas_pos_x};
    assign goal_rot = {i_in.goal_rot_z, i_in.goal_rot_y, i_in.goal_rot_x};
    assign meas_rot = {i_in.meas_rot_z, i_in.meas_rot_y, i_in.meas_rot_x};

    svpc_lane u_lin (
        .i_clk    (i_clk),
        .i_goal   (goal_pos),
        .i_meas   (meas_pos),
        .i_gain   (r_gain),
        .i_limit  (r_limit),
        .i_lim_sq (r_lim_sq),
        .o_vel    (lin_vel)
    );

    svpc_lane u_ang (
        .i_clk    (i_clk),
        .i_goal   (goal_rot),
        .i_meas   (meas_rot),
        .i_gain   (r_gain),
        .i_limit  (r_limit),
        .i_lim_sq (r_lim_sq),
        .o_vel    (ang_vel)
    );

    assign o_out.lin_vel_x = lin_vel[0];
    assign o_out.lin_vel_y = lin_vel[1];
    assign o_out.lin_vel_z = lin_vel[2];
    assign o_out.ang_vel_x = ang_vel[0];
    assign o_out.ang_vel_y = ang_vel[1];
    assign o_out.ang_vel_z = ang_vel[2];

    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, LAT))
        else $error("result strobe without a started transaction");

    a_gain_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && i_cfg_index == REG_GAIN |=> r_gain == $past(i_cfg_data[GAIN_W-1:0]))
        else $error("gain register write lost");

    a_limit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && i_cfg_index == REG_SPEED_LIMIT
        |=> r_limit == $past(i_cfg_data[LIMIT_W-1:0]))
        else $error("speed limit register write lost");

    a_lim_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $stable(r_limit) |=> r_lim_sq == $past(r_limit) * $past(r_limit))
        else $error("squared limit out of step with limit");

endmodule

FILE: verif/tb_saturated_vector_p_controller.sv
`timescale 1ns / 100ps

module tb_saturated_vector_p_controller;
    import svpc_pkg::*;

    localparam int  TIMEOUT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES   = 80;
    localparam int  NUM_RANDOM     = 1830;
    localparam longint VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint VMIN = -(64'sd1 <<< (VALUE_WIDTH - 1));

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_in                   i_in;
    logic                  o_strobe;
    t_out                  o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    saturated_vector_p_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    logic [GAIN_W-1:0]  ctl_gain;
    logic [LIMIT_W-1:0] ctl_limit;
    t_out               vel_queue[$];
    int                 err_count;
    longint             cycle_count;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] clamp_val(longint v);
        if (v > VMAX) v = VMAX;
        if (v < VMIN) v = VMIN;
        return v[VALUE_WIDTH-1:0];
    endfunction

    function automatic t_vec limited_velocity(t_vec goal, t_vec meas);
        longint          err;
        longint          ctl;
        longint          mag[3];
        bit              neg[3];
        bit              wide;
        bit              big;
        longint unsigned n2;
        longint unsigned lim;
        longint unsigned n;
        longint          r;
        t_vec            res;
        wide = 0;
        for (int i = 0; i < 3; i++) begin
            err = longint'($signed(goal[i])) - longint'($signed(meas[i]));
            // arithmetic shift is a floor: rounds ties toward +inf
            ctl = (err * longint'(ctl_gain) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            neg[i] = ctl < 0;
            mag[i] = neg[i] ? -ctl : ctl;
        end
        do begin
            big = 0;
            for (int i = 0; i < 3; i++) if (mag[i] >= (64'sd1 <<< 30)) big = 1;
            if (big) begin
                wide = 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >>> 1;
            end
        end while (big);
        n2 = 0;
        for (int i = 0; i < 3; i++) n2 += longint'(mag[i]) * longint'(mag[i]);
        lim = ctl_limit;
        if (!wide && n2 <= lim * lim) begin
            for (int i = 0; i < 3; i++) res[i] = clamp_val(neg[i] ? -mag[i] : mag[i]);
            return res;
        end
        n = int_sqrt(n2);
        for (int i = 0; i < 3; i++) begin
            r = 0;
            if (n != 0) r = (longint'(mag[i]) * lim + (n >> 1)) / n;
            res[i] = clamp_val(neg[i] ? -r : r);
        end
        return res;
    endfunction

    function automatic t_out velocity_of(t_in p);
        t_vec lin;
        t_vec ang;
        t_out o;
        lin = limited_velocity({p.goal_pos_x, p.goal_pos_y, p.goal_pos_z},
                               {p.meas_pos_x, p.meas_pos_y, p.meas_pos_z});
        ang = limited_velocity({p.goal_rot_x, p.goal_rot_y, p.goal_rot_z},
                               {p.meas_rot_x, p.meas_rot_y, p.meas_rot_z});
        o.lin_vel_x = lin[2];
        o.lin_vel_y = lin[1];
        o.lin_vel_z = lin[0];
        o.ang_vel_x = ang[2];
        o.ang_vel_y = ang[1];
        o.ang_vel_z = ang[0];
        return o;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out exp_v;
        if (i_rst_n && o_strobe) begin
            if (vel_queue.size() == 0) begin
                $error("unexpected result %h", o_out);
                err_count++;
            end else begin
                exp_v = vel_queue.pop_front();
                if (o_out.lin_vel_x !== exp_v.lin_vel_x) begin
                    $error("lin_vel_x exp %h got %h", exp_v.lin_vel_x, o_out.lin_vel_x);
                    err_count++;
                end
                if (o_out.lin_vel_y !== exp_v.lin_vel_y) begin
                    $error("lin_vel_y exp %h got %h", exp_v.lin_vel_y, o_out.lin_vel_y);
                    err_count++;
                end
                if (o_out.lin_vel_z !== exp_v.lin_vel_z) begin
                    $error("lin_vel_z exp %h got %h", exp_v.lin_vel_z, o_out.lin_vel_z);
                    err_count++;
                end
                if (o_out.ang_vel_x !== exp_v.ang_vel_x) begin
                    $error("ang_vel_x exp %h got %h", exp_v.ang_vel_x, o_out.ang_vel_x);
                    err_count++;
                end
                if (o_out.ang_vel_y !== exp_v.ang_vel_y) begin
                    $error("ang_vel_y exp %h got %h", exp_v.ang_vel_y, o_out.ang_vel_y);
                    err_count++;
                end
                if (o_out.ang_vel_z !== exp_v.ang_vel_z) begin
                    $error("ang_vel_z exp %h got %h", exp_v.ang_vel_z, o_out.ang_vel_z);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // valid drops after each write, which keeps back-to-back writes apart
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_GAIN) ctl_gain = data[GAIN_W-1:0];
        else if (idx == REG_SPEED_LIMIT) ctl_limit = data[LIMIT_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // t_out is all zero when no expectation is typed in
    // start stays high into the next transaction when there is no gap
    task automatic send_pose(t_in p, bit use_fixed, t_out fixed_v, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= p;
        do @(posedge i_clk); while (o_busy);
        vel_queue.insert(vel_queue.size(), use_fixed ? fixed_v : velocity_of(p));
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (vel_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_vec rand_vec(int mode);
        t_vec v;
        for (int i = 0; i < 3; i++) begin
            case (mode)
                0: v[i] = VALUE_WIDTH'($urandom);
                1: v[i] = VALUE_WIDTH'($urandom_range(0, 2000) - 1000);
                default: v[i] = $urandom_range(0, 1) ? VMAX[VALUE_WIDTH-1:0]
                                                     : VMIN[VALUE_WIDTH-1:0];
            endcase
        end
        return v;
    endfunction

    function automatic t_in rand_pose();
        t_vec gp, gr, mp, mr;
        gp = rand_vec($urandom_range(0, 2));
        gr = rand_vec($urandom_range(0, 2));
        mp = rand_vec($urandom_range(0, 2));
        mr = rand_vec($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) mp = gp;
        return {gp, gr, mp, mr};
    endfunction

    typedef struct {
        t_in  pose;
        bit   fixed;
        t_out vel;
    } t_row;

    t_row                  dir_rows[$];
    t_in                   p;
    t_out                  z;
    logic [VALUE_WIDTH-1:0] mx, mn, sl;
    logic [GAIN_W-1:0]     gains[4];
    logic [LIMIT_W-1:0]    limits[4];

    initial begin
        err_count   = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_GAIN;
        i_cfg_data  = '0;
        ctl_gain    = GAIN_RESET;
        ctl_limit   = LIMIT_RESET;
        z  = '0;
        mx = VMAX[VALUE_WIDTH-1:0];
        mn = VMIN[VALUE_WIDTH-1:0];
        sl = VALUE_WIDTH'(LIMIT_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings
        dir_rows.insert(dir_rows.size(), '{'0, 1, z});          // zero error gives zero
        p = '0; p.goal_pos_x = 24'd65536;                       // 1.0 m -> 0.1, above limit
        dir_rows.insert(dir_rows.size(), '{p, 1, '{lin_vel_x: sl, default: '0}});
        p = '0; p.meas_rot_y = 24'd65536;
        dir_rows.insert(dir_rows.size(), '{p, 1, '{ang_vel_y: -sl, default: '0}});
        p = '0; p.goal_pos_z = 24'd1000;                        // below limit, passes
        dir_rows.insert(dir_rows.size(), '{p, 0, z});
        p = '0; p.goal_pos_x = mx; p.meas_pos_x = mn;           // widest error
        dir_rows.insert(dir_rows.size(), '{p, 1, '{lin_vel_x: sl, default: '0}});
        p = {{12{mx}}};
        dir_rows.insert(dir_rows.size(), '{p, 1, z});
        p = '0; p.goal_pos_x = mx; p.goal_pos_y = mx; p.goal_pos_z = mn;
        p.goal_rot_x = mn; p.meas_rot_y = mn; p.meas_rot_z = mx;
        dir_rows.insert(dir_rows.size(), '{p, 0, z});
        p = '0; p.goal_pos_x = 24'd32768;                       // exactly on limit-ish
        dir_rows.insert(dir_rows.size(), '{p, 0, z});
        p = '0; p.goal_pos_x = 24'd1; p.meas_pos_y = 24'd1;     // rounding
        dir_rows.insert(dir_rows.size(), '{p, 0, z});
        p = '0; p.goal_rot_x = 24'd20000; p.goal_rot_y = 24'd20000; p.goal_rot_z = 24'd20000;
        dir_rows.insert(dir_rows.size(), '{p, 0, z});
        foreach (dir_rows[k]) send_pose(dir_rows[k].pose, dir_rows[k].fixed,
                                        dir_rows[k].vel, 0);
        wait_idle();

        // extreme settings: huge gain hits wide vectors, big limit hits output clamp
        write_reg(REG_GAIN, 24'hFFFFFF);
        write_reg(REG_SPEED_LIMIT, 24'h7FFFFF);
        p = '0; p.goal_pos_x = mx; p.meas_pos_x = mn;
        p.goal_rot_x = 24'd65536; p.goal_rot_y = mn;
        send_pose(p, 0, z, 0);
        send_pose(rand_pose(), 0, z, 0);
        wait_idle();
        write_reg(REG_GAIN, '0);
        write_reg(REG_SPEED_LIMIT, '0);
        send_pose(rand_pose(), 1, z, 0);
        wait_idle();
        write_reg(REG_GAIN, 24'd65536);
        write_reg(REG_SPEED_LIMIT, '0);                         // zero limit: nonzero -> zero
        p = '0; p.goal_pos_x = 24'd100;
        send_pose(p, 1, z, 0);
        wait_idle();

        gains  = '{24'd6554, 24'd65536, 24'hFFFFFF, 24'd1};
        limits = '{23'd3277, 23'h7FFFFF, 23'd65536, 23'd0};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_GAIN, (ph < 4) ? gains[ph] : CFG_DATA_W'($urandom));
            write_reg(REG_SPEED_LIMIT,
                      (ph < 4) ? CFG_DATA_W'(limits[3 - ph])
                               : CFG_DATA_W'($urandom_range(0, 8388607)));
            for (int k = 0; k < NUM_RANDOM / 6; k++)
                send_pose(rand_pose(), 0, z, 1);
            wait_idle();
        end

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
